// ----- design/sensor_packet_deframer_unit_assert.svh -----
// Assertion macros used by the deframer parser module.
// Each assertion is sampled on the rising clock; SPD_ASSERT is off while reset is low.
`ifndef SENSOR_PACKET_DEFRAMER_UNIT_ASSERT_SVH
`define SENSOR_PACKET_DEFRAMER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define SPD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SPD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPD_ASSERT(label, clk, rst_n, prop, msg)
`define SPD_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ----- design/spd_pkg.sv -----
`timescale 1ns / 1ps

package spd_pkg;

  // Packet layout
  localparam int TIMESTAMP_BYTES = 4;
  localparam int PAYLOAD_BYTES   = 8;
  localparam int CNT_W           = 4;

  // Configuration registers
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 1'b1;

  localparam logic [7:0] START_MARKER_RST = 8'h53;
  localparam logic [7:0] END_MARKER_RST   = 8'h45;

  // Output item width: type, id, timestamp, payload, check byte
  localparam int REC_W = 120;

  // One finished packet record
  typedef struct packed {
    logic [7:0]         check_byte;
    logic signed [63:0] payload;
    logic [31:0]        time_stamp;
    logic [7:0]         sensor_id;
    logic [7:0]         data_type;
  } spd_rec_t;

endpackage

// ----- design/sensor_packet_deframer_unit.sv -----
`timescale 1ns / 1ps

// Sensor packet deframer. Takes one received byte per item and emits one packet
// record per good frame: start marker, type, sensor id, 4-byte little-endian
// timestamp, 8-byte little-endian signed payload, a nonzero check byte (zero
// bytes before it are skipped; it is not verified) and the end marker. A bad end
// marker drops the frame; the byte after a good frame is ignored. One byte is
// accepted every cycle while the output register is empty or being read; the
// record reaches out_tvalid the cycle after its end marker is accepted. The user
// must write start and end markers (reset 0x53, 0x45) via cfg_* while idle, unchecked.
module sensor_packet_deframer_unit import spd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,   // 0 start_marker, 1 end_marker
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,    // [7:0] rx_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [7:0] data_type, [15:8] sensor_id, [47:16] time_stamp,
  // [111:48] payload, [119:112] check_byte
  output logic [REC_W-1:0]      out_tdata
);

  logic     byte_acc;
  logic     rec_valid;
  spd_rec_t rec;
  spd_rec_t out_rec;
  logic     slot_free;

  assign in_tready = slot_free;
  assign byte_acc  = in_tvalid && in_tready;

  spd_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .byte_acc  (byte_acc),
    .rx_byte   (in_tdata),
    .rec_valid (rec_valid),
    .rec       (rec)
  );

  spd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (rec_valid),
    .rec       (rec),
    .take      (out_tready),
    .slot_free (slot_free),
    .valid     (out_tvalid),
    .data      (out_rec)
  );

  // Pack first field into the lowest bits
  assign out_tdata = {out_rec.check_byte, out_rec.payload, out_rec.time_stamp,
                      out_rec.sensor_id, out_rec.data_type};

endmodule

// ----- design/spd_parse.sv -----
`timescale 1ns / 1ps

`include "sensor_packet_deframer_unit_assert.svh"

// Byte-level packet parser: phase machine, field accumulators, marker registers.
module spd_parse import spd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  byte_acc,
  input  logic [7:0]            rx_byte,
  output logic                  rec_valid,
  output spd_rec_t              rec
);

  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_TYPE  = 3'd1;
  localparam logic [2:0] PH_ID    = 3'd2;
  localparam logic [2:0] PH_TIME  = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_CHECK = 3'd5;
  localparam logic [2:0] PH_END   = 3'd6;
  localparam logic [2:0] PH_DONE  = 3'd7;

  logic [7:0]       start_r;
  logic [7:0]       end_r;
  logic [2:0]       phase_r,  phase_nxt;
  logic [CNT_W-1:0] cnt_r,    cnt_nxt;
  logic [31:0]      ts_r,     ts_nxt;
  logic [63:0]      pl_r,     pl_nxt;
  logic [7:0]       type_r,   type_nxt;
  logic [7:0]       id_r,     id_nxt;
  logic [7:0]       chk_r,    chk_nxt;
  logic [CNT_W-1:0] cnt_inc;
  logic [63:0]      placed;

  // Byte k of a field lands at bits 8k
  assign cnt_inc = cnt_r + CNT_W'(1);
  assign placed  = 64'(rx_byte) << {cnt_r[2:0], 3'b000};

  // Marker registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= START_MARKER_RST;
      end_r   <= END_MARKER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_MARKER: start_r <= cfg_wdata;
        CFG_END_MARKER:   end_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Phase machine and accumulators
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    ts_nxt    = ts_r;
    pl_nxt    = pl_r;
    type_nxt  = type_r;
    id_nxt    = id_r;
    chk_nxt   = chk_r;
    rec_valid = 1'b0;
    if (byte_acc) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (rx_byte == start_r) phase_nxt = PH_TYPE;
        end
        PH_TYPE: begin
          type_nxt  = rx_byte;
          phase_nxt = PH_ID;
        end
        PH_ID: begin
          id_nxt    = rx_byte;
          cnt_nxt   = '0;
          ts_nxt    = '0;
          pl_nxt    = '0;
          phase_nxt = PH_TIME;
        end
        PH_TIME: begin
          ts_nxt = ts_r | placed[31:0];
          if (cnt_inc >= CNT_W'(TIMESTAMP_BYTES)) begin
            cnt_nxt   = '0;
            phase_nxt = PH_DATA;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
        PH_DATA: begin
          pl_nxt = pl_r | placed;
          if (cnt_inc >= CNT_W'(PAYLOAD_BYTES)) begin
            cnt_nxt   = '0;
            phase_nxt = PH_CHECK;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
        PH_CHECK: begin
          // zero bytes are padding before the check byte
          if (rx_byte != 8'h00) begin
            chk_nxt   = rx_byte;
            phase_nxt = PH_END;
          end
        end
        PH_END: begin
          if (rx_byte == end_r) begin
            rec_valid = 1'b1;
            phase_nxt = PH_DONE;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
        default: begin
          // byte after a good packet is dropped
          phase_nxt = PH_HUNT;
          cnt_nxt   = '0;
          ts_nxt    = '0;
          pl_nxt    = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      cnt_r   <= '0;
      ts_r    <= '0;
      pl_r    <= '0;
      type_r  <= '0;
      id_r    <= '0;
      chk_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      ts_r    <= ts_nxt;
      pl_r    <= pl_nxt;
      type_r  <= type_nxt;
      id_r    <= id_nxt;
      chk_r   <= chk_nxt;
    end
  end

  // Record built from the held fields
  assign rec.data_type  = type_r;
  assign rec.sensor_id  = id_r;
  assign rec.time_stamp = ts_r;
  assign rec.payload    = pl_r;
  assign rec.check_byte = chk_r;

  `SPD_ASSERT(a_rec_from_end, clk, rst_n, rec_valid |-> (byte_acc && phase_r == PH_END), "record outside end phase")
  `SPD_ASSERT(a_done_to_hunt, clk, rst_n, (byte_acc && phase_r == PH_DONE) |=> (phase_r == PH_HUNT && cnt_r == '0), "done phase did not return to hunt")
  `SPD_ASSERT(a_rec_then_done, clk, rst_n, rec_valid |=> (phase_r == PH_DONE && chk_r != 8'h00), "record without done phase or with zero check byte")
  `SPD_ASSERT(a_cnt_range, clk, rst_n, cnt_r < CNT_W'(PAYLOAD_BYTES), "byte count out of range")

endmodule

// ----- design/spd_out_reg.sv -----
`timescale 1ns / 1ps

// Output register for finished records; frees its slot in the cycle it is taken.
module spd_out_reg import spd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     load,
  input  spd_rec_t rec,
  input  logic     take,
  output logic     slot_free,
  output logic     valid,
  output spd_rec_t data
);

  logic     valid_r, valid_nxt;
  spd_rec_t data_r,  data_nxt;

  assign slot_free = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = rec;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid = valid_r;
  assign data  = data_r;

endmodule
